// ===== design/ipv4_frame_filter_macros.svh =====
// assertion macros shared by the ipv4 frame filter checkers
`ifndef IPV4_FRAME_FILTER_MACROS_SVH
`define IPV4_FRAME_FILTER_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define IFF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define IFF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ipv4ff_pkg.sv =====
// types and constants of the ipv4 frame filter
package ipv4ff_pkg;

  typedef enum logic [1:0] {
    VERDICT_ACCEPT     = 2'd0,
    VERDICT_INVALID    = 2'd1,
    VERDICT_NOT_LOCAL  = 2'd2,
    VERDICT_WRONG_PROT = 2'd3
  } verdict_t;

  // configuration register indexes
  localparam logic [1:0] CFG_LOCAL_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_EXP_PROTOCOL  = 2'd1;
  localparam logic [1:0] CFG_MAX_FRAME_LEN = 2'd2;

  localparam logic [31:0] LOCAL_ADDRESS_RST = 32'h0A00_0002;
  localparam logic [7:0]  EXP_PROTOCOL_RST  = 8'd1;
  localparam logic [10:0] MAX_FRAME_LEN_RST = 11'd1514;

  localparam logic [11:0] COUNT_MAX = 12'hFFF;

  // byte positions within the frame
  localparam logic [11:0] POS_ETYPE_HI = 12'd12;
  localparam logic [11:0] POS_ETYPE_LO = 12'd13;
  localparam logic [11:0] POS_VER_IHL  = 12'd14;
  localparam logic [11:0] POS_TLEN_HI  = 12'd16;
  localparam logic [11:0] POS_TLEN_LO  = 12'd17;
  localparam logic [11:0] POS_FRAG_HI  = 12'd20;
  localparam logic [11:0] POS_FRAG_LO  = 12'd21;
  localparam logic [11:0] POS_PROTO    = 12'd23;
  localparam logic [11:0] POS_DST_FIRST = 12'd30;
  localparam logic [11:0] POS_DST_LAST  = 12'd33;
  localparam logic [11:0] POS_SUM_FIRST = 12'd14;
  localparam logic [11:0] POS_SUM_LAST  = 12'd33;

  // header checks
  localparam logic [11:0] MIN_FRAME_LEN  = 12'd34;
  localparam logic [15:0] ETYPE_IPV4     = 16'h0800;
  localparam logic [7:0]  VER_IHL_BASIC  = 8'h45;
  localparam logic [15:0] MIN_TOTAL_LEN  = 16'd20;
  localparam logic [15:0] ETH_HDR_LEN    = 16'd14;
  localparam logic [16:0] SUM_GOOD       = 17'h0FFFF;
  localparam logic [15:0] FRAG_MASK      = 16'h3FFF;

  // captured header fields and running state of one frame
  typedef struct packed {
    logic [11:0] byte_count;
    logic [16:0] sum;
    logic [15:0] ether_type;
    logic [7:0]  version_ihl;
    logic [15:0] total_length;
    logic [15:0] fragment_field;
    logic [7:0]  protocol;
    logic [31:0] dest_address;
  } hdr_t;

endpackage

// ===== design/ipv4ff_parser.sv =====
// byte counter, header field capture and ones' complement sum
module ipv4ff_parser
  import ipv4ff_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic [7:0] frame_byte,
  input  logic       last_byte,
  output hdr_t       hdr_upd
);

  hdr_t        hdr_r;
  hdr_t        hdr_nxt;
  logic [7:0]  held_r;
  logic [7:0]  held_upd;
  logic [7:0]  held_nxt;
  logic [17:0] sum_raw;
  logic [11:0] pos;

  always_comb begin
    pos      = hdr_r.byte_count;
    hdr_upd  = hdr_r;
    held_upd = held_r;
    sum_raw  = {1'b0, hdr_r.sum} + {2'b00, held_r, frame_byte};

    case (pos)
      POS_ETYPE_HI: hdr_upd.ether_type     = {frame_byte, 8'h00};
      POS_ETYPE_LO: hdr_upd.ether_type     = {hdr_r.ether_type[15:8], frame_byte};
      POS_VER_IHL:  hdr_upd.version_ihl    = frame_byte;
      POS_TLEN_HI:  hdr_upd.total_length   = {frame_byte, 8'h00};
      POS_TLEN_LO:  hdr_upd.total_length   = {hdr_r.total_length[15:8], frame_byte};
      POS_FRAG_HI:  hdr_upd.fragment_field = {frame_byte, 8'h00};
      POS_FRAG_LO:  hdr_upd.fragment_field = {hdr_r.fragment_field[15:8], frame_byte};
      POS_PROTO:    hdr_upd.protocol       = frame_byte;
      default: begin
        if (pos inside {[POS_DST_FIRST:POS_DST_LAST]}) begin
          hdr_upd.dest_address = {hdr_r.dest_address[23:0], frame_byte};
        end
      end
    endcase

    // even positions hold the high byte, odd ones add the pair and fold the carry
    if (pos inside {[POS_SUM_FIRST:POS_SUM_LAST]}) begin
      if (!pos[0]) begin
        held_upd = frame_byte;
      end else begin
        hdr_upd.sum = {1'b0, sum_raw[15:0]} + {15'd0, sum_raw[17:16]};
      end
    end

    if (hdr_r.byte_count < COUNT_MAX) begin
      hdr_upd.byte_count = hdr_r.byte_count + 12'd1;
    end
  end

  always_comb begin
    hdr_nxt  = hdr_r;
    held_nxt = held_r;
    if (en) begin
      if (last_byte) begin
        hdr_nxt  = '0;
        held_nxt = '0;
      end else begin
        hdr_nxt  = hdr_upd;
        held_nxt = held_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r  <= '0;
      held_r <= '0;
    end else begin
      hdr_r  <= hdr_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

// ===== design/ipv4ff_judge.sv =====
// verdict from the captured header and the configuration
module ipv4ff_judge
  import ipv4ff_pkg::*;
(
  input  hdr_t        hdr,
  input  logic [31:0] local_address,
  input  logic [7:0]  expected_protocol,
  input  logic [10:0] max_frame_length,
  output verdict_t    verdict
);

  logic [15:0] tlen_limit;
  logic        bad;

  always_comb begin
    tlen_limit = {4'd0, hdr.byte_count} - ETH_HDR_LEN;
    bad = (hdr.byte_count < MIN_FRAME_LEN)
       || (hdr.byte_count > {1'b0, max_frame_length})
       || (hdr.ether_type != ETYPE_IPV4)
       || (hdr.version_ihl != VER_IHL_BASIC)
       || (hdr.total_length < MIN_TOTAL_LEN)
       || (hdr.total_length > tlen_limit)
       || (hdr.sum != SUM_GOOD)
       || ((hdr.fragment_field & FRAG_MASK) != 16'd0);

    if (bad) begin
      verdict = VERDICT_INVALID;
    end else if (hdr.dest_address != local_address) begin
      verdict = VERDICT_NOT_LOCAL;
    end else if (hdr.protocol != expected_protocol) begin
      verdict = VERDICT_WRONG_PROT;
    end else begin
      verdict = VERDICT_ACCEPT;
    end
  end

endmodule

// ===== design/ipv4_frame_filter.sv =====
// ipv4 frame filter: checks ipv4 header of ethernet frames, one verdict per frame
//
// The frame enters one byte per transfer, in wire order, with in_tlast on the final
// byte. A byte is taken every cycle: the input register feeds the parser, which
// captures the ethertype, version/IHL, total length, fragment field, protocol and
// destination address and folds a ones' complement sum over header bytes 14..33.
// On the final byte the verdict is formed from the updated fields in the same cycle
// and loaded into the result register. Only a final byte waits on the result
// side: it is held in the input register while an earlier result is not yet taken,
// all other bytes pass through regardless of out_tready. Configuration is written
// through the cfg port; the user must write it only while no frame is in flight,
// which the block itself does not enforce, and a write takes effect at once.
module ipv4_frame_filter
  import ipv4ff_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] frame_byte
  input  logic        in_tlast,    // last_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [1:0] verdict, [13:2] frame_length, [15:14] zero
  // configuration writes
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  // configuration registers
  logic [31:0] local_address_r,     local_address_nxt;
  logic [7:0]  expected_protocol_r, expected_protocol_nxt;
  logic [10:0] max_frame_length_r,  max_frame_length_nxt;

  // input register
  logic        in_valid_r, in_valid_nxt;
  logic [7:0]  in_byte_r,  in_byte_nxt;
  logic        in_last_r,  in_last_nxt;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_data_r,  out_data_nxt;

  logic        advance;
  hdr_t        hdr_upd;
  verdict_t    verdict;

  // a held byte moves on unless it is final and the result register is still full
  assign advance   = in_valid_r && (!in_last_r || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  ipv4ff_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (advance),
    .frame_byte (in_byte_r),
    .last_byte  (in_last_r),
    .hdr_upd    (hdr_upd)
  );

  ipv4ff_judge u_judge (
    .hdr               (hdr_upd),
    .local_address     (local_address_r),
    .expected_protocol (expected_protocol_r),
    .max_frame_length  (max_frame_length_r),
    .verdict           (verdict)
  );

  // configuration write decode, writes beyond the list are dropped
  always_comb begin
    local_address_nxt     = local_address_r;
    expected_protocol_nxt = expected_protocol_r;
    max_frame_length_nxt  = max_frame_length_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_LOCAL_ADDRESS: local_address_nxt     = cfg_wdata;
        CFG_EXP_PROTOCOL:  expected_protocol_nxt = cfg_wdata[7:0];
        CFG_MAX_FRAME_LEN: max_frame_length_nxt  = cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  // input register loads on every accepted transfer
  always_comb begin
    in_valid_nxt = in_valid_r;
    in_byte_nxt  = in_byte_r;
    in_last_nxt  = in_last_r;
    if (in_tready) begin
      in_valid_nxt = in_tvalid;
      in_byte_nxt  = in_tdata;
      in_last_nxt  = in_tlast;
    end
  end

  // result register: loads on a final byte, empties when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (advance && in_last_r) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {2'b00, hdr_upd.byte_count, verdict};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_address_r     <= LOCAL_ADDRESS_RST;
      expected_protocol_r <= EXP_PROTOCOL_RST;
      max_frame_length_r  <= MAX_FRAME_LEN_RST;
      in_valid_r          <= 1'b0;
      out_valid_r         <= 1'b0;
    end else begin
      local_address_r     <= local_address_nxt;
      expected_protocol_r <= expected_protocol_nxt;
      max_frame_length_r  <= max_frame_length_nxt;
      in_valid_r          <= in_valid_nxt;
      out_valid_r         <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    in_byte_r  <= in_byte_nxt;
    in_last_r  <= in_last_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== design/ipv4ff_checker.sv =====
// port-level checks of the ipv4 frame filter and their binding
`include "ipv4_frame_filter_macros.svh"

module ipv4ff_checker
  import ipv4ff_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  logic [1:0]  verdict;
  logic [11:0] frame_length;

  assign verdict      = out_tdata[1:0];
  assign frame_length = out_tdata[13:2];

  // a result not taken stays put
  `IFF_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // padding bits of the result stay zero
  `IFF_ASSERT_NOW(a_out_pad, out_tvalid, out_tdata[15:14] == 2'b00, "result padding not zero")

  // a short frame is always judged invalid
  `IFF_ASSERT_NOW(a_short_invalid, out_tvalid && (frame_length < MIN_FRAME_LEN), verdict == VERDICT_INVALID, "short frame not invalid")

  // any frame past the length check fits an 11-bit maximum
  `IFF_ASSERT_NOW(a_len_range, out_tvalid && (verdict != VERDICT_INVALID), frame_length <= 12'd2047, "passed frame too long")

endmodule

bind ipv4_frame_filter ipv4ff_checker u_ipv4ff_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== bench/tb_ipv4_frame_filter.sv =====
// self-checking bench for the ipv4 frame filter: directed frames, then random frames
module tb_ipv4_frame_filter;
  timeunit 1ns;
  timeprecision 1ps;

  import ipv4ff_pkg::*;

  // out-of-range register index, writes to it must be dropped
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  // cycles without any transfer before the run is called dead
  localparam int unsigned STALL_LIMIT = 2000;
  localparam logic [31:0] OTHER_ADDRESS = 32'h0A00_0003;

  // how a generated frame departs from a clean ipv4 header
  typedef enum logic [3:0] {
    FLAW_NONE,
    FLAW_ETYPE,
    FLAW_VER,
    FLAW_TLEN_SHORT,
    FLAW_TLEN_LONG,
    FLAW_CSUM,
    FLAW_MF,
    FLAW_OFFSET,
    FLAW_DF,
    FLAW_ZERO,
    FLAW_NOISE
  } flaw_e;

  // receiver back-pressure patterns
  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_COIN,
    SINK_SPARSE,
    SINK_RARE
  } sink_mode_e;

  typedef struct packed {
    logic [12:0] len;
    flaw_e       flaw;
    logic [31:0] dst;
    logic [7:0]  proto;
    logic [15:0] tlen;      // zero picks a legal total length at random
    logic        typed;     // verdict below is written in rather than predicted
    verdict_t    verdict;
  } frame_row_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [11:0] length;
  } verdict_rec_t;

  // directed frames, all under the reset register values
  localparam frame_row_t PLAN [0:17] = '{
    // smallest clean frame
    '{13'd34,   FLAW_NONE,       LOCAL_ADDRESS_RST, 8'd1, 16'd20, 1'b1, VERDICT_ACCEPT},
    // frames too short to hold a header
    '{13'd33,   FLAW_NONE,       LOCAL_ADDRESS_RST, 8'd1, 16'd0,  1'b1, VERDICT_INVALID},
    '{13'd1,    FLAW_NONE,       LOCAL_ADDRESS_RST, 8'd1, 16'd0,  1'b1, VERDICT_INVALID},
    '{13'd13,   FLAW_NONE,       LOCAL_ADDRESS_RST, 8'd1, 16'd0,  1'b1, VERDICT_INVALID},
    // one broken header field at a time
    '{13'd34,   FLAW_ETYPE,      LOCAL_ADDRESS_RST, 8'd1, 16'd0,  1'b1, VERDICT_INVALID},
    '{13'd34,   FLAW_VER,        LOCAL_ADDRESS_RST, 8'd1, 16'd0,  1'b1, VERDICT_INVALID},
    '{13'd34,   FLAW_TLEN_SHORT, LOCAL_ADDRESS_RST, 8'd1, 16'd0,  1'b1, VERDICT_INVALID},
    '{13'd34,   FLAW_TLEN_LONG,  LOCAL_ADDRESS_RST, 8'd1, 16'd0,  1'b1, VERDICT_INVALID},
    '{13'd34,   FLAW_CSUM,       LOCAL_ADDRESS_RST, 8'd1, 16'd0,  1'b1, VERDICT_INVALID},
    '{13'd34,   FLAW_MF,         LOCAL_ADDRESS_RST, 8'd1, 16'd0,  1'b1, VERDICT_INVALID},
    '{13'd34,   FLAW_OFFSET,     LOCAL_ADDRESS_RST, 8'd1, 16'd0,  1'b1, VERDICT_INVALID},
    // don't-fragment alone is ignored
    '{13'd34,   FLAW_DF,         LOCAL_ADDRESS_RST, 8'd1, 16'd0,  1'b1, VERDICT_ACCEPT},
    '{13'd34,   FLAW_ZERO,       LOCAL_ADDRESS_RST, 8'd1, 16'd0,  1'b1, VERDICT_INVALID},
    // address and protocol checks, and their precedence
    '{13'd34,   FLAW_NONE,       OTHER_ADDRESS,     8'd1, 16'd0,  1'b1, VERDICT_NOT_LOCAL},
    '{13'd34,   FLAW_NONE,       LOCAL_ADDRESS_RST, 8'd6, 16'd0,  1'b1, VERDICT_WRONG_PROT},
    '{13'd34,   FLAW_NONE,       OTHER_ADDRESS,     8'd6, 16'd0,  1'b1, VERDICT_NOT_LOCAL},
    '{13'd34,   FLAW_MF,         OTHER_ADDRESS,     8'd6, 16'd0,  1'b1, VERDICT_INVALID},
    '{13'd34,   FLAW_NONE,       32'hFFFF_FFFF,     8'hFF, 16'd0, 1'b0, VERDICT_ACCEPT}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;    // [7:0] frame_byte
  logic        in_tlast = 1'b0;  // last_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;        // [1:0] verdict, [13:2] frame_length, [15:14] zero
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  // register shadow kept by the header predictor
  logic [31:0] set_local;
  logic [7:0]  set_proto;
  logic [10:0] set_max_len;

  // per-frame parser state of the predictor
  hdr_t        parse_st;
  logic [7:0]  parse_held;

  verdict_rec_t pending_verdicts[$];
  logic [7:0]   frame_bytes[$];

  int unsigned  mismatch_count = 0;
  int unsigned  burst_left = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  sink_tick = 0;
  sink_mode_e   sink_mode = SINK_OPEN;

  ipv4_frame_filter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic note_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // header predictor: one byte in, a verdict out on the final byte
  function automatic void filter_byte(input logic [7:0] b, input logic last,
                                      output logic done, output verdict_t v,
                                      output logic [11:0] n);
    logic [11:0] pos;
    logic [17:0] s;
    logic        bad;
    pos = parse_st.byte_count;
    done = 1'b0;
    v = VERDICT_ACCEPT;
    n = '0;
    // field capture at fixed positions, big-endian
    if (pos == POS_ETYPE_HI) parse_st.ether_type = {b, 8'h00};
    else if (pos == POS_ETYPE_LO) parse_st.ether_type[7:0] = b;
    else if (pos == POS_VER_IHL) parse_st.version_ihl = b;
    else if (pos == POS_TLEN_HI) parse_st.total_length = {b, 8'h00};
    else if (pos == POS_TLEN_LO) parse_st.total_length[7:0] = b;
    else if (pos == POS_FRAG_HI) parse_st.fragment_field = {b, 8'h00};
    else if (pos == POS_FRAG_LO) parse_st.fragment_field[7:0] = b;
    else if (pos == POS_PROTO) parse_st.protocol = b;
    else if (pos >= POS_DST_FIRST && pos <= POS_DST_LAST)
      parse_st.dest_address = {parse_st.dest_address[23:0], b};
    // ones' complement fold over header words, end-around carry each word
    if (pos >= POS_SUM_FIRST && pos <= POS_SUM_LAST) begin
      if (!pos[0]) begin
        parse_held = b;
      end else begin
        s = parse_st.sum + {parse_held, b};
        s = s[15:0] + s[17:16];
        parse_st.sum = s[16:0];
      end
    end
    if (parse_st.byte_count != COUNT_MAX) parse_st.byte_count++;
    if (last) begin
      n = parse_st.byte_count;
      bad = (n < MIN_FRAME_LEN) || (n > {1'b0, set_max_len}) ||
            (parse_st.ether_type != ETYPE_IPV4) ||
            (parse_st.version_ihl != VER_IHL_BASIC) ||
            (parse_st.total_length < MIN_TOTAL_LEN) ||
            (int'(parse_st.total_length) > int'(n) - int'(ETH_HDR_LEN)) ||
            (parse_st.sum != SUM_GOOD) ||
            ((parse_st.fragment_field & FRAG_MASK) != '0);
      if (bad) v = VERDICT_INVALID;
      else if (parse_st.dest_address != set_local) v = VERDICT_NOT_LOCAL;
      else if (parse_st.protocol != set_proto) v = VERDICT_WRONG_PROT;
      done = 1'b1;
      parse_st = '0;
      parse_held = '0;
    end
  endfunction

  // fills frame_bytes with an ethernet frame carrying an ipv4 header
  function automatic void build_frame(input int unsigned len, input flaw_e flaw,
                                      input logic [31:0] dst, input logic [7:0] proto,
                                      input logic [15:0] tlen_in);
    logic [7:0]  h [0:33];
    logic [17:0] acc;
    logic [15:0] word;
    logic [15:0] tl;
    logic [12:0] off;
    frame_bytes.delete();
    for (int i = 0; i < 34; i++) h[i] = 8'($urandom_range(0, 255));
    if (flaw != FLAW_NOISE) begin
      if (tlen_in != '0) tl = tlen_in;
      else if (len >= 34) tl = 16'($urandom_range(20, len - 14));
      else tl = MIN_TOTAL_LEN;
      {h[12], h[13]} = ETYPE_IPV4;
      h[14] = VER_IHL_BASIC;
      {h[16], h[17]} = tl;
      // DF is free to toggle, MF and offset stay clear
      h[20] = ($urandom_range(0, 1) != 0) ? 8'h40 : 8'h00;
      h[21] = 8'h00;
      h[23] = proto;
      {h[30], h[31], h[32], h[33]} = dst;
      case (flaw)
        FLAW_ETYPE:      h[12 + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
        FLAW_VER:        h[14] = VER_IHL_BASIC ^ 8'($urandom_range(1, 255));
        FLAW_TLEN_SHORT: {h[16], h[17]} = 16'($urandom_range(0, 19));
        FLAW_TLEN_LONG:  {h[16], h[17]} = 16'(len - 14 + $urandom_range(1, 200));
        FLAW_MF:         h[20][5] = 1'b1;
        FLAW_OFFSET: begin
          off = 13'($urandom_range(1, 8191));
          h[20][4:0] = off[12:8];
          h[21] = off[7:0];
        end
        FLAW_DF:         h[20] = 8'h40;
        FLAW_ZERO:       for (int i = 14; i < 34; i++) h[i] = 8'h00;
        default: ;
      endcase
      // header checksum so the receiver's fold lands on all ones
      if (flaw != FLAW_ZERO) begin
        h[24] = 8'h00;
        h[25] = 8'h00;
        acc = '0;
        for (int i = 14; i < 34; i += 2) begin
          acc = acc + {h[i], h[i + 1]};
          acc = acc[15:0] + acc[17:16];
        end
        acc = acc[15:0] + acc[17:16];
        word = ~acc[15:0];
        {h[24], h[25]} = word;
      end
      // single bit flip in the checksum can never fold back to all ones
      if (flaw == FLAW_CSUM) h[24 + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
    end
    for (int unsigned i = 0; i < len; i++)
      frame_bytes.push_back((i < 34) ? h[i] : 8'($urandom_range(0, 255)));
  endfunction

  // one byte transfer, with bursty gaps on the sender side
  task automatic push_byte(input logic [7:0] b, input logic last);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4))
        @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    burst_left--;
  endtask

  // sends frame_bytes; the expectation is queued as the final byte transfers
  task automatic send_frame(input logic typed, input verdict_t typed_v,
                            input logic [11:0] typed_len);
    logic         done;
    verdict_t     v;
    logic [11:0]  n;
    verdict_rec_t rec;
    int unsigned  last_idx;
    last_idx = frame_bytes.size() - 1;
    for (int unsigned i = 0; i <= last_idx; i++) begin
      push_byte(frame_bytes[i], i == last_idx);
      filter_byte(frame_bytes[i], i == last_idx, done, v, n);
      if (done) begin
        rec.verdict = typed ? typed_v : v;
        rec.length  = typed ? typed_len : n;
        pending_verdicts.push_back(rec);
      end
    end
  endtask

  task automatic random_frame();
    int unsigned pick;
    int unsigned len;
    int unsigned hi;
    flaw_e       f;
    logic [31:0] d;
    logic [7:0]  p;
    pick = $urandom_range(0, 99);
    d = ($urandom_range(0, 4) != 0) ? set_local : $urandom;
    p = ($urandom_range(0, 4) != 0) ? set_proto : 8'($urandom_range(0, 255));
    hi = (set_max_len < 64) ? set_max_len : 64;
    len = $urandom_range(34, hi);
    f = FLAW_NONE;
    // mostly clean headers with random content, some at the length limit
    if (pick < 10) begin
      // length limit edge, only where the limit keeps frames short
      if (set_max_len < 128) len = set_max_len + $urandom_range(0, 1);
    end
    else if (pick < 60) ;
    else if (pick < 85) f = flaw_e'($urandom_range(int'(FLAW_ETYPE), int'(FLAW_ZERO)));
    else if (pick < 93) len = $urandom_range(1, 33);
    else begin
      f = FLAW_NOISE;
      len = $urandom_range(1, 80);
    end
    build_frame(len, f, d, p, '0);
    send_frame(1'b0, VERDICT_ACCEPT, '0);
  endtask

  task automatic write_one(input logic [1:0] idx, input logic [31:0] val);
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    case (idx)
      CFG_LOCAL_ADDRESS: set_local = val;
      CFG_EXP_PROTOCOL:  set_proto = val[7:0];
      CFG_MAX_FRAME_LEN: set_max_len = val[10:0];
      default: ;
    endcase
  endtask

  // back-to-back register writes, write enable dropped once at the end
  task automatic program_regs(input logic [31:0] loc, input logic [31:0] prot,
                              input logic [31:0] mx);
    write_one(CFG_UNUSED, $urandom);
    write_one(CFG_LOCAL_ADDRESS, loc);
    write_one(CFG_EXP_PROTOCOL, prot);
    write_one(CFG_MAX_FRAME_LEN, mx);
    cfg_wr_en <= 1'b0;
  endtask

  // block is idle once every verdict is back and the pipe has drained
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // result side: compare each transfer with the oldest pending verdict
  always @(posedge clk) begin : result_check
    verdict_rec_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_verdicts.size() == 0) begin
        note_mismatch("result with nothing pending", out_tdata, 0);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_tdata[1:0] != want.verdict)
          note_mismatch("verdict", out_tdata[1:0], want.verdict);
        if (out_tdata[13:2] != want.length)
          note_mismatch("frame_length", out_tdata[13:2], want.length);
        if (out_tdata[15:14] != 2'b00)
          note_mismatch("tdata padding", out_tdata[15:14], 0);
      end
    end
  end

  // receiver back-pressure, mode reshuffled periodically
  always @(posedge clk) begin
    sink_tick <= sink_tick + 1;
    if (sink_tick % 97 == 0) sink_mode <= sink_mode_e'($urandom_range(0, 3));
    case (sink_mode)
      SINK_OPEN:   out_tready <= 1'b1;
      SINK_COIN:   out_tready <= 1'($urandom_range(0, 1));
      SINK_SPARSE: out_tready <= (sink_tick % 5 == 0);
      default:     out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // watchdog on cycles with no transfer anywhere
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    set_local   = LOCAL_ADDRESS_RST;
    set_proto   = EXP_PROTOCOL_RST;
    set_max_len = MAX_FRAME_LEN_RST;
    parse_st    = '0;
    parse_held  = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed frames under reset values
    foreach (PLAN[i]) begin
      build_frame(PLAN[i].len, PLAN[i].flaw, PLAN[i].dst, PLAN[i].proto, PLAN[i].tlen);
      send_frame(PLAN[i].typed, PLAN[i].verdict,
                 (PLAN[i].len > 13'd4095) ? 12'd4095 : PLAN[i].len[11:0]);
    end

    // lowest limits, with junk in the bits above the protocol and length registers
    wait_quiet();
    program_regs(32'h0000_0000, {24'hFF_FFFF, 8'h00}, {21'h1F_FFFF, 11'd34});
    repeat (2) random_frame();

    // highest limits
    wait_quiet();
    program_regs(32'hFFFF_FFFF, 32'h0000_00FF, 32'd2047);
    repeat (2) random_frame();

    // random settings with small length limits to keep frames short
    repeat (2) begin
      wait_quiet();
      program_regs($urandom, $urandom,
                   ($urandom & 32'hFFFF_F800) | $urandom_range(34, 100));
      random_frame();
    end

    wait_quiet();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
